// ===== hw/rtl/preemptive_priority_scheduler_assert.svh =====
// Assertion macros shared by the scheduler's checker.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define PPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scheduler assertion failed");

// Condition that must never be seen outside reset.
`define PPS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `PPS_ASSERT(lbl, clk, rst_n, !(expr))

`endif

// ===== hw/rtl/pps_pkg.sv =====
// Package with the types, constants and codes of the priority scheduler.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    // Size of the process table.
    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = 5;
    localparam int TICK_W    = 32;
    localparam int TIME_W    = 16;
    localparam int PRIO_W    = 8;
    localparam int SLOT_W    = 4;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // Request opcodes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // One request on the input channel.
    typedef struct packed {
        logic              opcode;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
    } t_in_req;

    // One result on the output channel.
    typedef struct packed {
        logic [SLOT_W-1:0] chosen_slot;
        logic              idle;
        logic              finished;
        logic [TICK_W-1:0] wait_ticks;
        logic [TICK_W-1:0] turnaround_ticks;
        logic              all_done;
        logic [TICK_W-1:0] now_tick;
    } t_out_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_en;
        logic pick_en;
        logic update_en;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_sts;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/pps_ctrl.sv =====
// Controller state machine of the priority scheduler.
`timescale 1ns / 1ps
`default_nettype none

module pps_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_opcode,
    output logic             o_in_ready,
    input  wire pps_pkg::t_sts i_sts,
    output pps_pkg::t_cmd    o_cmd
);
    import pps_pkg::*;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_opcode == OP_LOAD) begin
                        o_cmd.load_en = 1'b1;
                    end else begin
                        o_cmd.pick_en = 1'b1;
                        n_state       = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                // Wait until the output register can take the result.
                if (i_sts.out_free) begin
                    o_cmd.update_en = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pps_dp.sv =====
// Datapath of the priority scheduler: process table, selection tree and update.
`timescale 1ns / 1ps
`default_nettype none

module pps_dp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire pps_pkg::t_cmd         i_cmd,
    output pps_pkg::t_sts              o_sts,
    input  wire pps_pkg::t_in_req      i_req,
    input  wire logic                  i_cfg_we,
    input  wire logic [pps_pkg::CNT_W-1:0] i_cfg_wdata,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output pps_pkg::t_out_res          o_out_res
);
    import pps_pkg::*;

    // Process table (no reset: entries are defined once loaded).
    logic [TIME_W-1:0] r_arr  [MAX_PROCS];
    logic [TIME_W-1:0] r_bur  [MAX_PROCS];
    logic [PRIO_W-1:0] r_pri  [MAX_PROCS];
    logic [TIME_W-1:0] r_left [MAX_PROCS];

    logic [CNT_W-1:0]  r_count;
    logic [TICK_W-1:0] r_tick;
    logic [IDX_W-1:0]  r_pick;
    logic              r_found;
    logic              r_out_valid;
    t_out_res          r_out;

    logic [CNT_W-1:0]     n_slots;
    logic [MAX_PROCS-1:0] in_use;
    logic [MAX_PROCS-1:0] elig;

    // Number of slots in use, clamped to the table size.
    assign n_slots = (r_count > CNT_W'(MAX_PROCS)) ? CNT_W'(MAX_PROCS) : r_count;

    // A slot is eligible if in use, arrived and with work left.
    always_comb begin
        for (int i = 0; i < MAX_PROCS; i++) begin
            in_use[i] = CNT_W'(i) < n_slots;
            elig[i]   = in_use[i] && (r_left[i] != '0) &&
                        ((|r_tick[TICK_W-1:TIME_W]) || (r_arr[i] <= r_tick[TIME_W-1:0]));
        end
    end

    // Selection tree: smallest priority wins, the left (lower) slot wins a tie.
    logic [2*MAX_PROCS-1:0] nd_vld;
    logic [PRIO_W-1:0]      nd_pri [2*MAX_PROCS];
    logic [IDX_W-1:0]       nd_idx [2*MAX_PROCS];

    always_comb begin
        logic take_l;
        nd_vld = '0;
        for (int k = 0; k < 2*MAX_PROCS; k++) begin
            nd_pri[k] = '0;
            nd_idx[k] = '0;
        end
        for (int i = 0; i < MAX_PROCS; i++) begin
            nd_vld[MAX_PROCS+i] = elig[i];
            nd_pri[MAX_PROCS+i] = r_pri[i];
            nd_idx[MAX_PROCS+i] = IDX_W'(i);
        end
        for (int k = MAX_PROCS-1; k >= 1; k--) begin
            take_l = nd_vld[2*k] && (!nd_vld[2*k+1] || (nd_pri[2*k] <= nd_pri[2*k+1]));
            nd_vld[k] = nd_vld[2*k] || nd_vld[2*k+1];
            nd_pri[k] = take_l ? nd_pri[2*k] : nd_pri[2*k+1];
            nd_idx[k] = take_l ? nd_idx[2*k] : nd_idx[2*k+1];
        end
    end

    // Update of the chosen slot and the times of a completed process.
    logic [TIME_W-1:0]    pk_arr;
    logic [TIME_W-1:0]    pk_bur;
    logic [TIME_W-1:0]    pk_left;
    logic                 fin;
    logic [TICK_W:0]      end_tick;
    logic [TICK_W:0]      turn_ext;
    logic [TIME_W:0]      arr_bur;
    logic [TICK_W+1:0]    wait_ext;
    logic [TICK_W-1:0]    turn_val;
    logic [TICK_W-1:0]    wait_val;
    logic [MAX_PROCS-1:0] busy_after;
    t_out_res             n_out;

    always_comb begin
        pk_arr   = r_arr[r_pick];
        pk_bur   = r_bur[r_pick];
        pk_left  = r_left[r_pick];
        fin      = r_found && (pk_left == TIME_W'(1));
        end_tick = {1'b0, r_tick} + (TICK_W+1)'(1);
        turn_ext = end_tick - {{(TICK_W+1-TIME_W){1'b0}}, pk_arr};
        arr_bur  = {1'b0, pk_arr} + {1'b0, pk_bur};
        wait_ext = {1'b0, end_tick} - {{(TICK_W+1-TIME_W){1'b0}}, arr_bur};
        turn_val = turn_ext[TICK_W] ? TICK_MAX : turn_ext[TICK_W-1:0];
        if (wait_ext[TICK_W+1]) begin
            wait_val = '0;
        end else if (wait_ext[TICK_W]) begin
            wait_val = TICK_MAX;
        end else begin
            wait_val = wait_ext[TICK_W-1:0];
        end
        for (int i = 0; i < MAX_PROCS; i++) begin
            busy_after[i] = in_use[i] && (r_left[i] != '0) &&
                            !(fin && (r_pick == IDX_W'(i)));
        end
        n_out.chosen_slot      = r_found ? SLOT_W'(r_pick) : '0;
        n_out.idle             = !r_found;
        n_out.finished         = fin;
        n_out.wait_ticks       = fin ? wait_val : '0;
        n_out.turnaround_ticks = fin ? turn_val : '0;
        n_out.all_done         = (busy_after == '0);
        n_out.now_tick         = r_tick;
    end

    // Table writes: loads and the decrement of the chosen slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en && (int'(i_req.slot) < MAX_PROCS)) begin
            r_arr[i_req.slot[IDX_W-1:0]]  <= i_req.arrival;
            r_bur[i_req.slot[IDX_W-1:0]]  <= i_req.burst;
            r_pri[i_req.slot[IDX_W-1:0]]  <= i_req.prio;
            r_left[i_req.slot[IDX_W-1:0]] <= i_req.burst;
        end else if (i_cmd.update_en && r_found) begin
            r_left[r_pick] <= pk_left - TIME_W'(1);
        end
    end

    // Chosen slot, captured when a tick request is accepted, and the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pick_en) begin
            r_pick <= nd_idx[1];
        end
        if (i_cmd.update_en) begin
            r_out <= n_out;
        end
    end

    // Control registers: slot count, tick counter, found flag, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_tick      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (i_cmd.pick_en) begin
                r_found <= nd_vld[1];
            end
            if (i_cmd.update_en && (r_tick != TICK_MAX)) begin
                r_tick <= r_tick + TICK_W'(1);
            end
            if (i_cmd.update_en) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_res      = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/preemptive_priority_scheduler.sv =====
// Top level of the preemptive priority scheduler.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-------------------------
//  input    | in        | i_in_valid / o_in_ready   | i_in_req  (t_in_req)
//  output   | out       | o_out_valid / i_out_ready | o_out_res (t_out_res)
//  config   | in        | i_cfg_we (no wait)        | i_cfg_wdata (slot count)
//
// A load request writes the table when it is accepted. For a tick request,
// the selection tree over all table slots is registered when the request is
// accepted; the update state then writes the chosen slot and the output register.
// Reset (synchronous, active low) clears the slot count, the tick counter and
// the output valid; table entries are defined only once loaded.
// A stalled output holds a tick request in its update cycle until the result
// register frees; a new request may be accepted while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire pps_pkg::t_in_req           i_in_req,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output pps_pkg::t_out_res               o_out_res,
    input  wire logic                       i_cfg_we,
    input  wire logic [pps_pkg::CNT_W-1:0]  i_cfg_wdata
);
    import pps_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Controller.
    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_req.opcode),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    pps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/pps_checker.sv =====
// Port-level checker of the priority scheduler and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "preemptive_priority_scheduler_assert.svh"

module pps_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire pps_pkg::t_in_req          i_in_req,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire pps_pkg::t_out_res         i_out_res
);
    import pps_pkg::*;

    logic idle_dirty;
    logic times_bad;
    logic tick_taken;

    // An idle tick that still carries a slot, a completion or a waiting time.
    assign idle_dirty = i_out_res.idle && (i_out_res.finished ||
                        (i_out_res.chosen_slot != '0) || (i_out_res.wait_ticks != '0));

    // Times without a completion, or a turnaround shorter than the waiting time.
    assign times_bad = (!i_out_res.finished && (i_out_res.turnaround_ticks != '0)) ||
                       (i_out_res.turnaround_ticks < i_out_res.wait_ticks);

    // A tick request taken on the input channel.
    assign tick_taken = i_in_valid && i_in_ready && (i_in_req.opcode == OP_TICK);

    // A stalled result holds its value.
    `PPS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_res))

    // An idle tick reports no slot, no completion and no waiting time.
    `PPS_ASSERT_NEVER(a_idle_clean, i_clk, i_rst_n, i_out_valid && idle_dirty)

    // A turnaround is reported only on completion, and turnaround never trails waiting.
    `PPS_ASSERT_NEVER(a_times, i_clk, i_rst_n, i_out_valid && times_bad)

    // An accepted tick request blocks the input for its update cycle.
    `PPS_ASSERT(a_tick_busy, i_clk, i_rst_n, tick_taken |=> !i_in_ready)

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_req    (i_in_req),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_res   (o_out_res)
);

`default_nettype wire

// ===== bench/pps_schedule_checker.sv =====
// Checker that mirrors the scheduler's process table and compares every tick report.
`timescale 1ns / 1ps

module pps_schedule_checker
    import pps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in_req          i_in_req,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out_res         i_out_res,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);

    // Shadow copy of the process table and the scheduler's counters.
    logic [TIME_W-1:0] arrive_mem [MAX_PROCS];
    logic [TIME_W-1:0] burst_mem  [MAX_PROCS];
    logic [PRIO_W-1:0] prio_mem   [MAX_PROCS];
    logic [TIME_W-1:0] left_mem   [MAX_PROCS];
    logic [TICK_W-1:0] cur_tick;
    logic [CNT_W-1:0]  proc_count;

    // Tick reports predicted but not yet seen on the output channel.
    t_out_res expected_reports [$];
    int       mismatches;

    // Runs one scheduling tick on the shadow table and returns its report.
    function automatic t_out_res schedule_one_tick();
        int          n_used;
        int          pick;
        logic        found;
        logic [63:0] end_t;
        logic [63:0] span;
        t_out_res    rep;

        n_used = (proc_count > MAX_PROCS) ? MAX_PROCS : int'(proc_count);
        found  = 1'b0;
        pick   = 0;
        rep    = '0;

        // Smallest priority number among arrived, unfinished processes; the
        // strict compare keeps the lowest slot on a tie.
        for (int i = 0; i < n_used; i++) begin
            if ({16'b0, arrive_mem[i]} <= cur_tick && left_mem[i] != '0) begin
                if (!found || prio_mem[i] < prio_mem[pick]) begin
                    pick  = i;
                    found = 1'b1;
                end
            end
        end

        if (found) begin
            left_mem[pick] = left_mem[pick] - 1'b1;
            if (left_mem[pick] == '0) begin
                end_t = {32'b0, cur_tick} + 64'd1;
                span  = end_t - {48'b0, arrive_mem[pick]};
                rep.finished = 1'b1;
                rep.turnaround_ticks = (span > {32'b0, TICK_MAX}) ? TICK_MAX : span[31:0];
                if (span >= {48'b0, burst_mem[pick]}) begin
                    span = span - {48'b0, burst_mem[pick]};
                    rep.wait_ticks = (span > {32'b0, TICK_MAX}) ? TICK_MAX : span[31:0];
                end
            end
            rep.chosen_slot = pick[SLOT_W-1:0];
        end
        rep.idle = !found;

        // All done is judged after this tick's update.
        rep.all_done = 1'b1;
        for (int i = 0; i < n_used; i++) begin
            if (left_mem[i] != '0) begin
                rep.all_done = 1'b0;
            end
        end

        rep.now_tick = cur_tick;
        if (cur_tick != TICK_MAX) begin
            cur_tick = cur_tick + 1'b1;
        end
        return rep;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compares one accepted report with the oldest prediction.
    task automatic check_report(input t_out_res got);
        t_out_res want;
        if (expected_reports.size() == 0) begin
            $error("tick report with no request outstanding: slot %0d, tick %0d",
                   got.chosen_slot, got.now_tick);
            mismatches++;
        end else begin
            want = expected_reports.pop_front();
            check_field("chosen_slot", 32'(want.chosen_slot), 32'(got.chosen_slot));
            check_field("idle", 32'(want.idle), 32'(got.idle));
            check_field("finished", 32'(want.finished), 32'(got.finished));
            check_field("wait_ticks", want.wait_ticks, got.wait_ticks);
            check_field("turnaround_ticks", want.turnaround_ticks, got.turnaround_ticks);
            check_field("all_done", 32'(want.all_done), 32'(got.all_done));
            check_field("now_tick", want.now_tick, got.now_tick);
        end
    endtask

    // Watch the configuration port and both channels at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PROCS; i++) begin
                arrive_mem[i] = '0;
                burst_mem[i]  = '0;
                prio_mem[i]   = '0;
                left_mem[i]   = '0;
            end
            cur_tick   = '0;
            proc_count = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                proc_count = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                check_report(i_out_res);
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_req.opcode == OP_LOAD) begin
                    if (int'(i_in_req.slot) < MAX_PROCS) begin
                        arrive_mem[i_in_req.slot] = i_in_req.arrival;
                        burst_mem[i_in_req.slot]  = i_in_req.burst;
                        prio_mem[i_in_req.slot]   = i_in_req.prio;
                        left_mem[i_in_req.slot]   = i_in_req.burst;
                    end
                end else begin
                    expected_reports.push_back(schedule_one_tick());
                end
            end
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== bench/tb_preemptive_priority_scheduler.sv =====
// Testbench top for the preemptive priority scheduler: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler;
    import pps_pkg::*;

    localparam int HOLD_LEN    = 300;
    localparam int ITEM_TARGET = 800;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_req          in_req    = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_res         out_res;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;

    // Flow-control knobs of the request and result sides; quiet is shared by both.
    logic quiet       = 1'b0;
    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;
    int   stall_left  = 0;

    int fail_count;
    int pending;
    int items_sent = 0;
    int ticks_sent = 0;

    preemptive_priority_scheduler i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_res   (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    pps_schedule_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_res    (out_res),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Gap length: mostly none or short, now and then long; none in quiet stretches.
    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Result side: random stalls, plus one long hold-off when the toggle flips.
    always @(posedge clk) begin : result_sink
        int gap;
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen  <= hold_toggle;
            stall_left <= HOLD_LEN;
            out_ready  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else begin
            gap = pick_gap();
            if (gap == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready  <= 1'b0;
                stall_left <= gap - 1;
            end
        end
    end

    function automatic t_in_req make_load(input int slot, input int arrival,
                                          input int burst, input int prio);
        t_in_req r;
        r.opcode  = OP_LOAD;
        r.slot    = SLOT_W'(slot);
        r.arrival = TIME_W'(arrival);
        r.burst   = TIME_W'(burst);
        r.prio    = PRIO_W'(prio);
        return r;
    endfunction

    // Tick request; the unused fields carry random junk.
    function automatic t_in_req make_tick();
        t_in_req r;
        r.opcode  = OP_TICK;
        r.slot    = SLOT_W'($urandom);
        r.arrival = TIME_W'($urandom);
        r.burst   = TIME_W'($urandom);
        r.prio    = PRIO_W'($urandom);
        return r;
    endfunction

    // Random process for one slot, mostly arriving close to the current tick.
    function automatic t_in_req random_process(input int slot);
        int arrival;
        int burst;
        int prio;
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            arrival = $urandom_range(0, 65535);
        end else if (r < 4) begin
            arrival = (ticks_sent > 3) ? ticks_sent - $urandom_range(0, 3) : 0;
        end else begin
            arrival = ticks_sent + $urandom_range(0, 6);
        end
        r = $urandom_range(0, 39);
        if (r == 0) begin
            burst = $urandom_range(0, 65535);
        end else if (r < 3) begin
            burst = 0;
        end else begin
            burst = $urandom_range(1, 6);
        end
        prio = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
        return make_load(slot, arrival, burst, prio);
    endfunction

    // Offers one request after a random gap and returns once it is accepted.
    task automatic send_req(input t_in_req r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        if (r.opcode == OP_TICK) begin
            ticks_sent++;
        end
    endtask

    // Stops offering requests until every predicted report has come back.
    task automatic drain_reports();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_count(input int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stimulus: directed corner cases first, then random scheduling rounds.
    initial begin : stimulus
        int phase;
        int budget;
        int n_ticks;
        int count_val;
        int burst;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: plain process, zero burst, a process that never
        // arrives with every field at its top value, a late high-priority
        // arrival that preempts, and a tie on priority with slot 0.
        send_req(make_load(0, 0, 3, 5));
        send_req(make_load(1, 0, 0, 0));
        send_req(make_load(2, 65535, 65535, 255));
        send_req(make_load(3, 2, 1, 0));
        send_req(make_load(4, 0, 2, 5));
        // With no slots in use the tick is idle and everything counts as done.
        send_req(make_tick());
        drain_reports();
        write_count(5);
        repeat (12) send_req(make_tick());

        // Random rounds: reload part of the table, then tick it through.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            drain_reports();
            if (phase == 0) begin
                count_val = 16;
            end else if (phase == 1) begin
                count_val = 31;
            end else begin
                case ($urandom_range(0, 7))
                    0: count_val = 0;
                    1: count_val = $urandom_range(17, 31);
                    2: count_val = 16;
                    default: count_val = $urandom_range(1, 15);
                endcase
            end
            write_count(count_val);
            quiet <= (phase % 5 == 3);

            budget = 0;
            for (int s = 0; s < MAX_PROCS; s++) begin
                if (phase == 0 || $urandom_range(0, 3) != 0) begin
                    send_req(random_process(s));
                    burst = int'(in_req.burst);
                    if (burst <= 6) begin
                        budget += burst;
                    end
                end
            end

            // Long hold-off on the result side while ticks keep coming.
            if (phase == 2) begin
                hold_toggle <= ~hold_toggle;
            end

            n_ticks = ((budget > 40) ? 40 : budget) + $urandom_range(0, 4);
            for (int k = 0; k < n_ticks; k++) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_req(random_process($urandom_range(0, MAX_PROCS - 1)));
                end
                send_req(make_tick());
            end
            phase++;
        end

        drain_reports();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== preemptive_priority_scheduler.f =====
+incdir+hw/rtl
hw/rtl/pps_pkg.sv
hw/rtl/pps_ctrl.sv
hw/rtl/pps_dp.sv
hw/rtl/preemptive_priority_scheduler.sv
hw/rtl/pps_checker.sv
bench/pps_schedule_checker.sv
bench/tb_preemptive_priority_scheduler.sv
